[src/lkd_pkg.sv]
// Package for the resistor-ladder keypad decoder with debounce.
// Holds the transfer payload types, the key band table and the ring sizing.
// No dependencies.
`timescale 1ns / 1ps

package lkd_pkg;

  // Debounce ring depth (valid range 2 to 16) and the width of its write pointer
  localparam int DEBOUNCE_DEPTH = 4;
  localparam int HIST_IDX_W     = (DEBOUNCE_DEPTH > 1) ? $clog2(DEBOUNCE_DEPTH) : 1;

  localparam int SAMPLE_W = 16;
  localparam int KEY_W    = 7;
  localparam int CODE_W   = 8;

  // Ascending band tops of the divider; a reading below a top maps to its key
  localparam int BAND_COUNT = 12;

  localparam logic [SAMPLE_W-1:0] BAND_TOP [BAND_COUNT] = '{
    16'h0140, 16'h03c0, 16'h06e0, 16'h0b00, 16'h0fc0, 16'h1560,
    16'h1d00, 16'h2720, 16'h34a0, 16'h4a20, 16'h6e00, 16'h9a80
  };

  // ASCII codes: '3' '6' '9' 'b' '2' '5' '8' '0' '1' '4' '7' 'k'
  localparam logic [KEY_W-1:0] BAND_KEY [BAND_COUNT] = '{
    7'h33, 7'h36, 7'h39, 7'h62, 7'h32, 7'h35,
    7'h38, 7'h30, 7'h31, 7'h34, 7'h37, 7'h6b
  };

  localparam logic [KEY_W-1:0]  KEY_NONE   = '0;
  localparam logic [CODE_W-1:0] PRESS_FLAG = 8'h80;

  // One sampling tick
  typedef struct packed {
    logic [SAMPLE_W-1:0] adc_sample;
    logic                hold;
  } in_t;

  // One tick result
  typedef struct packed {
    logic [KEY_W-1:0]  debounced_key;
    logic              event_valid;
    logic [CODE_W-1:0] event_code;
    logic              released;
  } out_t;

endpackage

[src/ladder_keypad_decoder_debounce.sv]
// Resistor-ladder keypad decoder with debounce, top level.
// One input transfer is one sampling tick: a left-adjusted 16-bit ADC reading and a hold
// flag. An unheld reading maps through twelve threshold bands to an ASCII key code
// (0 above the top band, including the no-key region), which enters a 4-deep ring; when
// all ring entries agree the debounced key takes that code, and a change yields an event
// (press: key | 0x80, release: old key with the released flag). Every input transfer
// gives exactly one result transfer: an input register, then the band compare, ring update
// and event logic, all combinational, into the result register. A new
// tick is taken every cycle while the result side keeps up; a result waiting on out_stall
// holds the input register, and in_stall rises only once both registers are full.
// Depends on lkd_pkg, lkd_ladder and lkd_debounce.
`timescale 1ns / 1ps

module ladder_keypad_decoder_debounce (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lkd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output lkd_pkg::out_t out_data
);

  logic                      s1_valid_r, s1_valid_nxt;
  lkd_pkg::in_t              s1_data_r;
  logic                      res_free;
  logic                      step;
  logic                      in_xfer;
  logic [lkd_pkg::KEY_W-1:0] key_code;

  // Input register drains into the result register whenever that can load
  assign step     = s1_valid_r && res_free;
  assign in_stall = s1_valid_r && !res_free;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
  end

  // Band lookup
  lkd_ladder u_ladder (
    .adc_sample (s1_data_r.adc_sample),
    .key_code   (key_code)
  );

  // Debounce and result register
  lkd_debounce u_debounce (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .hold      (s1_data_r.hold),
    .key_code  (key_code),
    .res_free  (res_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[src/lkd_ladder.sv]
// Threshold ladder: maps an ADC reading to an ASCII key code.
// Depends on lkd_pkg for the band table.
`timescale 1ns / 1ps

module lkd_ladder (
  input  logic [lkd_pkg::SAMPLE_W-1:0] adc_sample,
  output logic [lkd_pkg::KEY_W-1:0]    key_code
);

  // Parallel compares; the lowest band that holds the reading wins
  always_comb begin
    key_code = lkd_pkg::KEY_NONE;
    for (int b = lkd_pkg::BAND_COUNT - 1; b >= 0; b--) begin
      if (adc_sample < lkd_pkg::BAND_TOP[b]) begin
        key_code = lkd_pkg::BAND_KEY[b];
      end
    end
  end

endmodule

[src/lkd_debounce.sv]
// Debounce ring, stable key tracking, event generation and result register.
// Depends on lkd_pkg; fed by lkd_ladder through the top level.
`timescale 1ns / 1ps

module lkd_debounce (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,       // process one tick this cycle
  input  logic                      hold,
  input  logic [lkd_pkg::KEY_W-1:0] key_code,
  output logic                      res_free,   // result register can load
  output logic                      out_valid,
  input  logic                      out_stall,
  output lkd_pkg::out_t             out_data
);

  logic [lkd_pkg::KEY_W-1:0]      hist_r   [lkd_pkg::DEBOUNCE_DEPTH];
  logic [lkd_pkg::KEY_W-1:0]      hist_nxt [lkd_pkg::DEBOUNCE_DEPTH];
  logic [lkd_pkg::HIST_IDX_W-1:0] idx_r, idx_nxt;
  logic [lkd_pkg::KEY_W-1:0]      stable_r, stable_nxt;
  logic                           agree;
  logic                           out_valid_r, out_valid_nxt;
  lkd_pkg::out_t                  out_data_r, out_data_nxt;

  assign res_free = !(out_valid_r && out_stall);

  // Ring write: the new code lands at the write pointer
  always_comb begin
    for (int i = 0; i < lkd_pkg::DEBOUNCE_DEPTH; i++) begin
      hist_nxt[i] = hist_r[i];
    end
    if (!hold) begin
      hist_nxt[idx_r] = key_code;
    end
  end

  // Pointer wraps at the ring depth
  always_comb begin
    idx_nxt = idx_r;
    if (!hold) begin
      if (idx_r == lkd_pkg::HIST_IDX_W'(lkd_pkg::DEBOUNCE_DEPTH - 1)) begin
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  // All entries equal after the write
  always_comb begin
    agree = 1'b1;
    for (int i = 1; i < lkd_pkg::DEBOUNCE_DEPTH; i++) begin
      if (hist_nxt[i] != hist_nxt[0]) begin
        agree = 1'b0;
      end
    end
  end

  // Stable key update and event build
  always_comb begin
    stable_nxt   = stable_r;
    out_data_nxt = '0;
    if (!hold && agree && hist_nxt[0] != stable_r) begin
      stable_nxt               = hist_nxt[0];
      out_data_nxt.event_valid = 1'b1;
      if (hist_nxt[0] != lkd_pkg::KEY_NONE) begin
        out_data_nxt.event_code = {1'b0, hist_nxt[0]} | lkd_pkg::PRESS_FLAG;
      end else begin
        out_data_nxt.event_code = {1'b0, stable_r};
        out_data_nxt.released   = 1'b1;
      end
    end
    out_data_nxt.debounced_key = stable_nxt;
  end

  // Result register valid: loads on a step, holds while stalled
  always_comb begin
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_stall) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // Debounce state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lkd_pkg::DEBOUNCE_DEPTH; i++) begin
        hist_r[i] <= lkd_pkg::KEY_NONE;
      end
      idx_r       <= '0;
      stable_r    <= lkd_pkg::KEY_NONE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (step) begin
        for (int i = 0; i < lkd_pkg::DEBOUNCE_DEPTH; i++) begin
          hist_r[i] <= hist_nxt[i];
        end
        idx_r    <= idx_nxt;
        stable_r <= stable_nxt;
      end
    end
  end

  // Result payload needs no reset
  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // A press event carries the new stable key with the press flag
  a_press_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.event_valid && !out_data_r.released) |->
      (out_data_r.event_code[lkd_pkg::CODE_W-1] &&
       out_data_r.event_code[lkd_pkg::KEY_W-1:0] == out_data_r.debounced_key))
    else $error("press event code does not match debounced key");

  // A release leaves no key and names a real key
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.released) |->
      (out_data_r.event_valid && out_data_r.debounced_key == lkd_pkg::KEY_NONE &&
       out_data_r.event_code != '0 && !out_data_r.event_code[lkd_pkg::CODE_W-1]))
    else $error("malformed release event");

  // A held tick leaves the debounce state untouched
  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (step && hold) |=> ($stable(stable_r) && $stable(idx_r)))
    else $error("held tick changed debounce state");

  // Write pointer stays inside the ring
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(idx_r) < lkd_pkg::DEBOUNCE_DEPTH)
    else $error("ring pointer out of range");

  // A stalled result is not overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !step)
    else $error("result register loaded while stalled");
`endif

endmodule
